>>> design/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types, constants and saturation helper of the three-wheel mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package tws_pkg;

  // Operating modes
  typedef enum logic [1:0] {
    MODE_STABILIZED = 2'd0,
    MODE_POSITION   = 2'd1,
    MODE_DEVELOPER  = 2'd2,
    MODE_UNKNOWN    = 2'd3
  } tws_mode_e;

  // Configuration register indexes
  localparam logic CFG_SUM_LIMIT   = 1'b0;
  localparam logic CFG_MOTOR_LIMIT = 1'b1;

  localparam int unsigned LIMIT_W = 15;

  localparam logic [LIMIT_W-1:0] SUM_LIMIT_RST   = 15'd20480;  // 80.0
  localparam logic [LIMIT_W-1:0] MOTOR_LIMIT_RST = 15'd25600;  // 100.0

  // Mixing matrix, Q2.14
  localparam logic signed [31:0] COEF_A = 32'sd13378;
  localparam logic signed [31:0] COEF_B = 32'sd9459;
  localparam logic signed [31:0] COEF_C = 32'sd6689;
  localparam logic signed [31:0] COEF_D = 32'sd11585;

  typedef struct packed {
    logic               armed;
    tws_mode_e          mode;
    logic signed [15:0] roll_command;
    logic signed [15:0] pitch_command;
    logic signed [15:0] yaw_command;
  } tws_in_t;

  typedef struct packed {
    logic signed [15:0] motor_one;
    logic signed [15:0] motor_two;
    logic signed [15:0] motor_three;
  } tws_out_t;

  // Vector entering the matrix; negated roll needs 17 bits
  typedef struct packed {
    logic signed [16:0] neg_roll;
    logic signed [16:0] pitch;
    logic signed [16:0] yaw;
  } tws_vec_t;

  // Stage load enables
  typedef struct packed {
    logic accept;     // input word taken
    logic load_prod;  // product stage loads
    logic load_out;   // output stage loads
  } tws_pipe_t;

  // Symmetric saturation to +-lim; result always fits 16 bits
  function automatic logic signed [15:0] sat_sym(input logic signed [17:0] v,
                                                 input logic [LIMIT_W-1:0] lim);
    logic signed [17:0] hi;
    logic signed [17:0] lo;
    logic signed [17:0] r;
    hi = signed'({3'b000, lim});
    lo = -hi;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[15:0];
  endfunction

endpackage

`default_nettype wire

>>> design/tws_accum.sv
// ----------------------------------------------------------------------------
// tws_accum
// Running axis sums and selection of the vector that enters the mixer.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_accum import tws_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tws_pipe_t          pipe_i,
  input  wire tws_in_t            in_i,
  input  wire logic [LIMIT_W-1:0] sum_limit_i,
  output tws_vec_t                vec_o
);

  logic signed [15:0] roll_sum_q, pitch_sum_q, yaw_sum_q;
  logic signed [15:0] roll_sum_d, pitch_sum_d, yaw_sum_d;
  logic signed [15:0] r_sel, p_sel, y_sel;
  tws_vec_t           vec_q, vec_d;

  always_comb begin
    roll_sum_d  = sat_sym({{2{roll_sum_q[15]}}, roll_sum_q}
                          + {{2{in_i.roll_command[15]}}, in_i.roll_command}, sum_limit_i);
    pitch_sum_d = sat_sym({{2{pitch_sum_q[15]}}, pitch_sum_q}
                          + {{2{in_i.pitch_command[15]}}, in_i.pitch_command}, sum_limit_i);
    yaw_sum_d   = sat_sym({{2{yaw_sum_q[15]}}, yaw_sum_q}
                          + {{2{in_i.yaw_command[15]}}, in_i.yaw_command}, sum_limit_i);

    r_sel = '0;
    p_sel = '0;
    y_sel = '0;
    if (in_i.armed) begin
      unique case (in_i.mode)
        MODE_STABILIZED, MODE_POSITION: begin
          r_sel = in_i.roll_command;
          p_sel = in_i.pitch_command;
          y_sel = in_i.yaw_command;
        end
        MODE_DEVELOPER: begin
          r_sel = roll_sum_d;
          p_sel = pitch_sum_d;
          y_sel = yaw_sum_d;
        end
        default: begin
          r_sel = '0;
          p_sel = '0;
          y_sel = '0;
        end
      endcase
    end

    vec_d.neg_roll = -{r_sel[15], r_sel};
    vec_d.pitch    = {p_sel[15], p_sel};
    vec_d.yaw      = {y_sel[15], y_sel};
  end

  // sums move only for an armed developer-mode word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_sum_q  <= '0;
      pitch_sum_q <= '0;
      yaw_sum_q   <= '0;
    end else if (pipe_i.accept && in_i.armed && (in_i.mode == MODE_DEVELOPER)) begin
      roll_sum_q  <= roll_sum_d;
      pitch_sum_q <= pitch_sum_d;
      yaw_sum_q   <= yaw_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.accept) begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule

`default_nettype wire

>>> design/tws_mix.sv
// ----------------------------------------------------------------------------
// tws_mix
// Matrix products, row sums, floor to Q8.8 and speed saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_mix import tws_pkg::*; (
  input  wire logic               clk_i,
  input  wire tws_pipe_t          pipe_i,
  input  wire tws_vec_t           vec_i,
  input  wire logic [LIMIT_W-1:0] motor_limit_i,
  output tws_out_t                out_o
);

  // distinct products; rows share them with signs
  logic signed [31:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [31:0] row1, row2, row3;
  tws_out_t           out_q, out_d;

  always_ff @(posedge clk_i) begin
    if (pipe_i.load_prod) begin
      pa_q <= 32'(vec_i.neg_roll) * COEF_A;
      pb_q <= 32'(vec_i.yaw) * COEF_B;
      pc_q <= 32'(vec_i.neg_roll) * COEF_C;
      pd_q <= 32'(vec_i.pitch) * COEF_D;
    end
  end

  always_comb begin
    row1 = pa_q - pb_q;
    row2 = pd_q - pc_q - pb_q;
    row3 = -pd_q - pc_q - pb_q;
    // upper bits are the floor of the Q.22 sum over 2^14
    out_d.motor_one   = sat_sym(row1[31:14], motor_limit_i);
    out_d.motor_two   = sat_sym(row2[31:14], motor_limit_i);
    out_d.motor_three = sat_sym(row3[31:14], motor_limit_i);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

>>> design/three_wheel_speed_mixer.sv
// ----------------------------------------------------------------------------
// three_wheel_speed_mixer
// Three-wheel omni motor mixing matrix with developer-mode axis accumulators.
// ----------------------------------------------------------------------------
// Takes one command word per cycle while the output side is not stalled and
// returns one speed word per command, in order. Three register stages lie
// between command and speed word: the selected vector (where the developer-mode
// running sums are updated at acceptance), the four matrix products, and the
// saturated speeds. Each stage refills as it drains, so a waiting result does
// not stop input while an earlier stage is empty. Limits are written through
// cfg_we_i / cfg_addr_i / cfg_wdata_i and must only change while no word is
// in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module three_wheel_speed_mixer import tws_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration writes
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_addr_i,
  input  wire logic [LIMIT_W-1:0] cfg_wdata_i,
  // command channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire tws_in_t            in_data_i,
  // speed channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output tws_out_t                out_data_o
);

  logic [LIMIT_W-1:0] sum_limit_q, motor_limit_q;
  logic               vec_vld_q, prod_vld_q, out_vld_q;
  logic               rdy_vec, rdy_prod, rdy_out;
  tws_pipe_t          pipe;
  tws_vec_t           vec;

  // limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_limit_q   <= SUM_LIMIT_RST;
      motor_limit_q <= MOTOR_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_SUM_LIMIT:   sum_limit_q   <= cfg_wdata_i;
        CFG_MOTOR_LIMIT: motor_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // a stage can load when empty or when its content moves on this cycle
  assign rdy_out  = !out_vld_q || out_ready_i;
  assign rdy_prod = !prod_vld_q || rdy_out;
  assign rdy_vec  = !vec_vld_q || rdy_prod;

  assign pipe.accept    = in_valid_i && rdy_vec;
  assign pipe.load_prod = vec_vld_q && rdy_prod;
  assign pipe.load_out  = prod_vld_q && rdy_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (rdy_vec)  vec_vld_q  <= in_valid_i;
      if (rdy_prod) prod_vld_q <= vec_vld_q;
      if (rdy_out)  out_vld_q  <= prod_vld_q;
    end
  end

  tws_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pipe_i      (pipe),
    .in_i        (in_data_i),
    .sum_limit_i (sum_limit_q),
    .vec_o       (vec)
  );

  tws_mix u_mix (
    .clk_i         (clk_i),
    .pipe_i        (pipe),
    .vec_i         (vec),
    .motor_limit_i (motor_limit_q),
    .out_o         (out_data_o)
  );

  assign in_ready_o  = rdy_vec;
  assign out_valid_o = out_vld_q;

endmodule

`default_nettype wire

>>> design/tws_props.sv
// ----------------------------------------------------------------------------
// tws_props
// Port-level properties of the mixer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_props import tws_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire tws_in_t            in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire tws_out_t           out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled speed word changed or dropped");

  // draining output always frees the input
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output drains");

  // a disarmed or unknown-mode word comes out as zero speeds when the output keeps draining
  a_zero_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o
     && (!in_data_i.armed || (in_data_i.mode == MODE_UNKNOWN)))
    ##1 out_ready_i ##1 out_ready_i
    |=> out_valid_o && (out_data_o.motor_one == 16'sd0)
        && (out_data_o.motor_two == 16'sd0) && (out_data_o.motor_three == 16'sd0))
    else $error("inactive command gave nonzero speed");

endmodule

bind three_wheel_speed_mixer tws_props u_props (.*);

`default_nettype wire
